// ----- design/lbcd_pkg.sv -----
// Package for the LRU block cache directory: field widths, operation codes,
// result and control structures shared by the interfaces and the modules.
// Depends on nothing.
package lbcd_pkg;

    localparam int OP_W    = 2;
    localparam int BLOCK_W = 32;
    localparam int SLOT_W  = 6;

    // Default directory depth; the top level may be built smaller.
    localparam int CACHE_ENTRIES_DEF = 64;

    // Operation codes carried by an input item.
    localparam logic [OP_W-1:0] OP_REQUEST = 2'd0;
    localparam logic [OP_W-1:0] OP_CREATE  = 2'd1;
    localparam logic [OP_W-1:0] OP_MARK    = 2'd2;
    localparam logic [OP_W-1:0] OP_FLUSH   = 2'd3;

    // One result item.
    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic               hit;
        logic               fetch_needed;
        logic               writeback_needed;
        logic [BLOCK_W-1:0] writeback_block;
        logic               last;
    } t_result;

    // Commands from the sequencer to the tag unit.
    typedef struct packed {
        logic               rd_en;
        logic [SLOT_W-1:0]  rd_addr;
        logic               wr_en;
        logic [SLOT_W-1:0]  wr_addr;
        logic [BLOCK_W-1:0] wr_data;
    } t_tag_cmd;

    // Commands from the sequencer to the recency list.
    typedef struct packed {
        logic              start;
        logic [SLOT_W-1:0] slot;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
    } t_rec_cmd;

    // Status from the recency list back to the sequencer.
    typedef struct packed {
        logic              done;
        logic [SLOT_W-1:0] rd_data;
    } t_rec_status;

endpackage

// ----- design/lbcd_if.sv -----
// Handshake interfaces for the request and result channels of the directory.
// Depends on lbcd_pkg.

// Request channel: one item per operation.
interface lbcd_in_if;
    import lbcd_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [BLOCK_W-1:0] block_number;

    modport source (output valid, operation, block_number, input ready);
    modport sink   (input valid, operation, block_number, output ready);
endinterface

// Result channel: one or more items per request.
interface lbcd_out_if;
    import lbcd_pkg::*;

    logic               valid;
    logic               ready;
    logic [SLOT_W-1:0]  slot;
    logic               hit;
    logic               fetch_needed;
    logic               writeback_needed;
    logic [BLOCK_W-1:0] writeback_block;
    logic               last;

    modport source (output valid, slot, hit, fetch_needed, writeback_needed,
                    writeback_block, last, input ready);
    modport sink   (input valid, slot, hit, fetch_needed, writeback_needed,
                    writeback_block, last, output ready);
endinterface

// ----- design/lbcd_tag_unit.sv -----
// Tag store with a registered read port and the shared tag comparator.
// Depends on lbcd_pkg.
module lbcd_tag_unit #(
    parameter int CACHE_ENTRIES = lbcd_pkg::CACHE_ENTRIES_DEF
) (
    input  logic                      i_clk,
    input  lbcd_pkg::t_tag_cmd        i_cmd,
    input  logic [lbcd_pkg::BLOCK_W-1:0] i_key,
    output logic [lbcd_pkg::BLOCK_W-1:0] o_rd_data,
    output logic                      o_match
);
    import lbcd_pkg::*;

    localparam int IDX_W = $clog2(CACHE_ENTRIES);

    logic [BLOCK_W-1:0] r_mem [CACHE_ENTRIES];
    logic [BLOCK_W-1:0] r_rd_data;

    // Single write port and single registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr[IDX_W-1:0]] <= i_cmd.wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_cmd.rd_addr[IDX_W-1:0]];
        end
    end

    // The one comparator, checked against the tag read last cycle.
    assign o_match   = (r_rd_data == i_key);
    assign o_rd_data = r_rd_data;

endmodule

// ----- design/lbcd_recency_list.sv -----
// Recency list: slot numbers ordered from most recent to least recent, held in
// a memory, with a one-entry-per-cycle shift pass that moves a slot to the front.
// Depends on lbcd_pkg.
module lbcd_recency_list #(
    parameter int CACHE_ENTRIES = lbcd_pkg::CACHE_ENTRIES_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  lbcd_pkg::t_rec_cmd                     i_cmd,
    input  logic [$clog2(CACHE_ENTRIES+1)-1:0]     i_fill,
    output lbcd_pkg::t_rec_status                  o_status
);
    import lbcd_pkg::*;

    localparam int IDX_W  = $clog2(CACHE_ENTRIES);
    localparam int FILL_W = $clog2(CACHE_ENTRIES + 1);

    logic [IDX_W-1:0] r_mem [CACHE_ENTRIES];
    logic [IDX_W-1:0] r_rd_data;
    logic             r_active;
    logic             r_chk;
    logic [IDX_W-1:0] r_iss;
    logic [IDX_W-1:0] r_chk_idx;
    logic [IDX_W-1:0] r_carry;
    logic [IDX_W-1:0] r_key;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             stop;

    // During a pass the list owns the read port; otherwise the sequencer does.
    assign rd_en   = r_active || i_cmd.rd_en;
    assign rd_addr = r_active ? r_iss : i_cmd.rd_addr[IDX_W-1:0];

    // The pass ends where the moved slot was found, or one past the old tail.
    assign stop = r_chk && ((FILL_W'(r_chk_idx) == i_fill) || (r_rd_data == r_key));

    // Each checked position takes the carried slot and hands its old one on.
    always_ff @(posedge i_clk) begin
        if (r_chk) begin
            r_mem[r_chk_idx] <= r_carry;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Pass control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_chk    <= 1'b0;
        end else if (i_cmd.start) begin
            r_active <= 1'b1;
            r_chk    <= 1'b0;
        end else if (r_active) begin
            r_chk <= !stop;
            if (stop) begin
                r_active <= 1'b0;
            end
        end else begin
            r_chk <= 1'b0;
        end
    end

    // Pass addresses and the carried slot.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_iss   <= '0;
            r_carry <= i_cmd.slot[IDX_W-1:0];
            r_key   <= i_cmd.slot[IDX_W-1:0];
        end else if (r_active) begin
            r_chk_idx <= r_iss;
            if (r_iss != IDX_W'(CACHE_ENTRIES - 1)) begin
                r_iss <= r_iss + IDX_W'(1);
            end
            if (r_chk) begin
                r_carry <= r_rd_data;
            end
        end
    end

    assign o_status.done    = stop;
    assign o_status.rd_data = SLOT_W'(r_rd_data);

endmodule

// ----- design/lru_block_cache_directory.sv -----
// Top level of the LRU block cache directory: sequencer, valid and dirty bits,
// fill count and result register. Depends on lbcd_pkg, lbcd_if, lbcd_tag_unit
// and lbcd_recency_list.
//
//  Channel  Dir  Payload                                         Accepted when
//  i_req    in   operation, block_number                         valid && ready
//  o_rsp    out  slot, hit, fetch_needed, writeback_needed,      valid && ready
//                writeback_block, last
//
// A lookup scans the tag store one slot per cycle through the shared comparator.
// A hit other than a mark, or a fill, then runs the recency shift pass, one list
// position per cycle; an eviction first reads the victim slot from the list tail
// and then its tag. A flush reads each list entry in turn and the tag of each dirty
// slot. Reset clears valid bits, dirty bits and the fill count; no memory is swept.
// i_req.ready is high only between items; a result waits in the output register,
// and a stalled o_rsp holds the sequencer at its next result.
module lru_block_cache_directory #(
    parameter int CACHE_ENTRIES = lbcd_pkg::CACHE_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lbcd_in_if.sink           i_req,
    lbcd_out_if.source        o_rsp
);
    import lbcd_pkg::*;

    localparam int IDX_W  = $clog2(CACHE_ENTRIES);
    localparam int FILL_W = $clog2(CACHE_ENTRIES + 1);

    // Sequencer states.
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_SCAN    = 4'd1;
    localparam logic [3:0] S_VRD     = 4'd2;
    localparam logic [3:0] S_VSLOT   = 4'd3;
    localparam logic [3:0] S_VTAG    = 4'd4;
    localparam logic [3:0] S_PROMO   = 4'd5;
    localparam logic [3:0] S_RESULT  = 4'd6;
    localparam logic [3:0] S_FL_RD   = 4'd7;
    localparam logic [3:0] S_FL_SLOT = 4'd8;
    localparam logic [3:0] S_FL_TAG  = 4'd9;
    localparam logic [3:0] S_FL_END  = 4'd10;

    logic [3:0]               r_state,     n_state;
    logic [OP_W-1:0]          r_op,        n_op;
    logic [BLOCK_W-1:0]       r_blk,       n_blk;
    logic [IDX_W-1:0]         r_iss,       n_iss;
    logic                     r_iss_done,  n_iss_done;
    logic                     r_chk,       n_chk;
    logic [IDX_W-1:0]         r_chk_idx,   n_chk_idx;
    logic [IDX_W-1:0]         r_free,      n_free;
    logic [IDX_W-1:0]         r_slot,      n_slot;
    logic                     r_ins,       n_ins;
    logic [FILL_W-1:0]        r_rank,      n_rank;
    logic                     r_pend,      n_pend;
    logic [IDX_W-1:0]         r_pend_slot, n_pend_slot;
    logic [BLOCK_W-1:0]       r_pend_tag,  n_pend_tag;
    t_result                  r_res,       n_res;
    logic [CACHE_ENTRIES-1:0] r_valid,     n_valid;
    logic [CACHE_ENTRIES-1:0] r_dirty,     n_dirty;
    logic [FILL_W-1:0]        r_fill,      n_fill;
    logic                     r_out_valid;
    t_result                  r_out;

    t_tag_cmd                 tag_cmd;
    t_rec_cmd                 rec_cmd;
    t_rec_status              rec_st;
    logic [BLOCK_W-1:0]       tag_rd;
    logic                     tag_match;
    logic                     out_free;
    logic                     out_load;
    t_result                  out_data;
    logic [IDX_W-1:0]         free_c;
    logic [IDX_W-1:0]         list_slot;
    logic                     fetch;
    logic                     wb;

    lbcd_tag_unit #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_tag (
        .i_clk     (i_clk),
        .i_cmd     (tag_cmd),
        .i_key     (r_blk),
        .o_rd_data (tag_rd),
        .o_match   (tag_match)
    );

    lbcd_recency_list #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_rec (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (rec_cmd),
        .i_fill   (r_fill),
        .o_status (rec_st)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign fetch       = (r_op == OP_REQUEST);
    assign list_slot   = rec_st.rd_data[IDX_W-1:0];
    assign free_c      = r_valid[r_chk_idx] ? r_free : r_chk_idx;
    assign wb          = r_dirty[r_slot];

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_blk       = r_blk;
        n_iss       = r_iss;
        n_iss_done  = r_iss_done;
        n_chk       = r_chk;
        n_chk_idx   = r_chk_idx;
        n_free      = r_free;
        n_slot      = r_slot;
        n_ins       = r_ins;
        n_rank      = r_rank;
        n_pend      = r_pend;
        n_pend_slot = r_pend_slot;
        n_pend_tag  = r_pend_tag;
        n_res       = r_res;
        n_valid     = r_valid;
        n_dirty     = r_dirty;
        n_fill      = r_fill;
        tag_cmd     = '0;
        rec_cmd     = '0;
        out_load    = 1'b0;
        out_data    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op  = i_req.operation;
                    n_blk = i_req.block_number;
                    if (i_req.operation == OP_FLUSH) begin
                        n_rank  = '0;
                        n_pend  = 1'b0;
                        n_state = S_FL_RD;
                    end else begin
                        n_iss      = '0;
                        n_iss_done = 1'b0;
                        n_chk      = 1'b0;
                        n_free     = '0;
                        n_state    = S_SCAN;
                    end
                end
            end

            // Read one tag per cycle and compare the one read the cycle before.
            S_SCAN: begin
                tag_cmd.rd_en   = !r_iss_done;
                tag_cmd.rd_addr = SLOT_W'(r_iss);
                n_chk           = !r_iss_done;
                n_chk_idx       = r_iss;
                if (!r_iss_done) begin
                    if (r_iss == IDX_W'(CACHE_ENTRIES - 1)) begin
                        n_iss_done = 1'b1;
                    end else begin
                        n_iss = r_iss + IDX_W'(1);
                    end
                end
                if (r_chk) begin
                    n_free = free_c;
                    priority if (r_valid[r_chk_idx] && tag_match) begin
                        n_res.slot             = SLOT_W'(r_chk_idx);
                        n_res.hit              = 1'b1;
                        n_res.fetch_needed     = 1'b0;
                        n_res.writeback_needed = 1'b0;
                        n_res.writeback_block  = '0;
                        n_res.last             = 1'b1;
                        if (r_op == OP_MARK) begin
                            n_dirty[r_chk_idx] = 1'b1;
                            n_state            = S_RESULT;
                        end else begin
                            rec_cmd.start = 1'b1;
                            rec_cmd.slot  = SLOT_W'(r_chk_idx);
                            n_ins         = 1'b0;
                            n_state       = S_PROMO;
                        end
                    end else if (r_chk_idx == IDX_W'(CACHE_ENTRIES - 1)) begin
                        if (r_op == OP_MARK) begin
                            n_res      = '0;
                            n_res.last = 1'b1;
                            n_state    = S_RESULT;
                        end else if (r_fill < FILL_W'(CACHE_ENTRIES)) begin
                            // Miss with room: take the highest free slot.
                            tag_cmd.wr_en          = 1'b1;
                            tag_cmd.wr_addr        = SLOT_W'(free_c);
                            tag_cmd.wr_data        = r_blk;
                            n_valid[free_c]        = 1'b1;
                            n_dirty[free_c]        = 1'b0;
                            rec_cmd.start          = 1'b1;
                            rec_cmd.slot           = SLOT_W'(free_c);
                            n_ins                  = 1'b1;
                            n_res.slot             = SLOT_W'(free_c);
                            n_res.hit              = 1'b0;
                            n_res.fetch_needed     = fetch;
                            n_res.writeback_needed = 1'b0;
                            n_res.writeback_block  = '0;
                            n_res.last             = 1'b1;
                            n_state                = S_PROMO;
                        end else begin
                            n_state = S_VRD;
                        end
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end

            // Full directory: the victim is the tail of the recency list.
            S_VRD: begin
                rec_cmd.rd_en   = 1'b1;
                rec_cmd.rd_addr = SLOT_W'(CACHE_ENTRIES - 1);
                n_state         = S_VSLOT;
            end

            S_VSLOT: begin
                n_slot          = list_slot;
                tag_cmd.rd_en   = 1'b1;
                tag_cmd.rd_addr = SLOT_W'(list_slot);
                n_state         = S_VTAG;
            end

            S_VTAG: begin
                n_res.slot             = SLOT_W'(r_slot);
                n_res.hit              = 1'b0;
                n_res.fetch_needed     = fetch;
                n_res.writeback_needed = wb;
                n_res.writeback_block  = wb ? tag_rd : '0;
                n_res.last             = 1'b1;
                tag_cmd.wr_en          = 1'b1;
                tag_cmd.wr_addr        = SLOT_W'(r_slot);
                tag_cmd.wr_data        = r_blk;
                n_dirty[r_slot]        = 1'b0;
                rec_cmd.start          = 1'b1;
                rec_cmd.slot           = SLOT_W'(r_slot);
                n_ins                  = 1'b0;
                n_state                = S_PROMO;
            end

            // Wait for the recency pass; a fill grows the count only afterward.
            S_PROMO: begin
                if (rec_st.done) begin
                    if (r_ins) begin
                        n_fill = r_fill + FILL_W'(1);
                    end
                    n_state = S_RESULT;
                end
            end

            S_RESULT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_data = r_res;
                    n_state  = S_IDLE;
                end
            end

            // Flush walks the recency list from most recent to least recent.
            S_FL_RD: begin
                if (r_rank == r_fill) begin
                    n_state = S_FL_END;
                end else begin
                    rec_cmd.rd_en   = 1'b1;
                    rec_cmd.rd_addr = SLOT_W'(r_rank[IDX_W-1:0]);
                    n_state         = S_FL_SLOT;
                end
            end

            S_FL_SLOT: begin
                if (r_dirty[list_slot]) begin
                    n_dirty[list_slot] = 1'b0;
                    tag_cmd.rd_en      = 1'b1;
                    tag_cmd.rd_addr    = SLOT_W'(list_slot);
                    n_slot             = list_slot;
                    n_state            = S_FL_TAG;
                end else begin
                    n_rank  = r_rank + FILL_W'(1);
                    n_state = S_FL_RD;
                end
            end

            // The previous dirty entry goes out once a later one is known.
            S_FL_TAG: begin
                if (!r_pend || out_free) begin
                    if (r_pend) begin
                        out_load                  = 1'b1;
                        out_data.slot             = SLOT_W'(r_pend_slot);
                        out_data.writeback_needed = 1'b1;
                        out_data.writeback_block  = r_pend_tag;
                    end
                    n_pend      = 1'b1;
                    n_pend_slot = r_slot;
                    n_pend_tag  = tag_rd;
                    n_rank      = r_rank + FILL_W'(1);
                    n_state     = S_FL_RD;
                end
            end

            S_FL_END: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_data.last = 1'b1;
                    if (r_pend) begin
                        out_data.slot             = SLOT_W'(r_pend_slot);
                        out_data.writeback_needed = 1'b1;
                        out_data.writeback_block  = r_pend_tag;
                    end
                    n_pend  = 1'b0;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_dirty     <= '0;
            r_fill      <= '0;
            r_pend      <= 1'b0;
            r_chk       <= 1'b0;
            r_iss_done  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_dirty    <= n_dirty;
            r_fill     <= n_fill;
            r_pend     <= n_pend;
            r_chk      <= n_chk;
            r_iss_done <= n_iss_done;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_blk       <= n_blk;
        r_iss       <= n_iss;
        r_chk_idx   <= n_chk_idx;
        r_free      <= n_free;
        r_slot      <= n_slot;
        r_ins       <= n_ins;
        r_rank      <= n_rank;
        r_pend_slot <= n_pend_slot;
        r_pend_tag  <= n_pend_tag;
        r_res       <= n_res;
        if (out_load) begin
            r_out <= out_data;
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.slot             = r_out.slot;
    assign o_rsp.hit              = r_out.hit;
    assign o_rsp.fetch_needed     = r_out.fetch_needed;
    assign o_rsp.writeback_needed = r_out.writeback_needed;
    assign o_rsp.writeback_block  = r_out.writeback_block;
    assign o_rsp.last             = r_out.last;

endmodule

// ----- design/lbcd_checker.sv -----
// Port-level checks for the LRU block cache directory and the bind that
// attaches them to the top level. Depends on lbcd_pkg.
module lbcd_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic                         i_hit,
    input logic                         i_fetch_needed,
    input logic                         i_writeback_needed,
    input logic [lbcd_pkg::BLOCK_W-1:0] i_writeback_block,
    input logic                         i_last
);
    import lbcd_pkg::*;

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    // An accepted item closes the request channel.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second item accepted while one is in progress");

    // A hit never writes back and never fetches.
    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_hit |-> !i_writeback_needed && !i_fetch_needed)
        else $error("hit result asks for disk traffic");

    // The write-back block is zero unless a write-back is reported.
    a_wb_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_writeback_needed |-> i_writeback_block == '0)
        else $error("write-back block set without write-back");

    // A fetch is reported only on a final result item.
    a_fetch_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_fetch_needed |-> i_last)
        else $error("fetch reported on a non-final result");

endmodule

bind lru_block_cache_directory lbcd_checker u_lbcd_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_req.valid),
    .i_in_ready         (i_req.ready),
    .i_out_valid        (o_rsp.valid),
    .i_out_ready        (o_rsp.ready),
    .i_hit              (o_rsp.hit),
    .i_fetch_needed     (o_rsp.fetch_needed),
    .i_writeback_needed (o_rsp.writeback_needed),
    .i_writeback_block  (o_rsp.writeback_block),
    .i_last             (o_rsp.last)
);
